[rtl/c2p_pkg.sv]
// c2p_pkg: shared constants, pipeline stage type and arctangent table
// for the complex to polar converter. No dependencies.
package c2p_pkg;

  localparam int SAMPLE_WIDTH = 16;
  localparam int ITERATIONS   = 16;
  localparam int GUARD_BITS   = 16;
  localparam int DW           = SAMPLE_WIDTH + GUARD_BITS + 3;
  localparam int ZW           = 18;
  localparam int MW           = 16;
  localparam int AW           = 16;
  localparam int GAIN_W       = 24;
  localparam int LO_W         = 24;
  localparam int HI_W         = DW - 1 - LO_W;
  localparam int SUM_W        = HI_W + GAIN_W + 1;

  localparam logic [GAIN_W-1:0]    GAIN_Q24      = GAIN_W'(10188014);
  localparam logic signed [ZW-1:0] ANGLE_PI      = ZW'(25736);
  localparam logic signed [ZW-1:0] ANGLE_HALF_PI = ZW'(12868);

  typedef struct packed {
    logic                 bypass;
    logic signed [DW-1:0] x;
    logic signed [DW-1:0] y;
    logic signed [ZW-1:0] z;
    logic [MW-1:0]        bmag;
    logic signed [AW-1:0] bang;
  } c2p_stage_t;

  // round(atan(2^-i) * 8192)
  function automatic logic signed [ZW-1:0] atan_q13(input int unsigned i);
    case (i)
      0:       return ZW'(6434);
      1:       return ZW'(3798);
      2:       return ZW'(2007);
      3:       return ZW'(1019);
      4:       return ZW'(511);
      5:       return ZW'(256);
      6:       return ZW'(128);
      7:       return ZW'(64);
      8:       return ZW'(32);
      9:       return ZW'(16);
      10:      return ZW'(8);
      11:      return ZW'(4);
      12:      return ZW'(2);
      13:      return ZW'(1);
      default: return '0;
    endcase
  endfunction

endpackage

[rtl/c2p_sample_if.sv]
// c2p_sample_if: valid/ready channel carrying one complex sample.
// Depends on c2p_pkg.
interface c2p_sample_if import c2p_pkg::*; ();
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] real_part;
  logic signed [SAMPLE_WIDTH-1:0] imag_part;

  modport source (output valid, output real_part, output imag_part, input ready);
  modport sink   (input valid, input real_part, input imag_part, output ready);
endinterface

[rtl/c2p_polar_if.sv]
// c2p_polar_if: valid/ready channel carrying one magnitude/angle result.
// Depends on c2p_pkg.
interface c2p_polar_if import c2p_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [MW-1:0]        magnitude;
  logic signed [AW-1:0] angle;

  modport source (output valid, output magnitude, output angle, input ready);
  modport sink   (input valid, input magnitude, input angle, output ready);
endinterface

[rtl/complex_to_polar_converter.sv]
// complex_to_polar_converter: CORDIC rectangular to polar, top level.
// Throughput: one transaction per cycle while the skid entry is empty;
// stages are fold, ITERATIONS rotations, gain correction and the output register.
// A two-entry output buffer keeps input ready up while one result waits.
// Reset (rst, synchronous): clears all valid bits; no other state.
// Depends on c2p_pkg, c2p_sample_if, c2p_polar_if, c2p_fold, c2p_cordic, c2p_gain.
module complex_to_polar_converter import c2p_pkg::*; (
  input logic         clk,
  input logic         rst,
  c2p_sample_if.sink  sample,
  c2p_polar_if.source polar
);

  logic                 en;
  logic                 fold_valid;
  c2p_stage_t           fold_stage;
  logic                 rot_valid;
  c2p_stage_t           rot_stage;
  logic                 gain_valid;
  logic [MW-1:0]        gain_mag;
  logic signed [AW-1:0] gain_ang;
  logic                 push;

  logic                 out_valid;
  logic [MW-1:0]        out_mag;
  logic signed [AW-1:0] out_ang;
  logic                 skid_valid;
  logic [MW-1:0]        skid_mag;
  logic signed [AW-1:0] skid_ang;

  assign en           = !skid_valid;
  assign push         = en && gain_valid;
  assign sample.ready = en;

  c2p_fold u_fold (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (sample.valid),
    .real_part (sample.real_part),
    .imag_part (sample.imag_part),
    .out_valid (fold_valid),
    .out_stage (fold_stage)
  );

  c2p_cordic u_cordic (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (fold_valid),
    .in_stage  (fold_stage),
    .out_valid (rot_valid),
    .out_stage (rot_stage)
  );

  c2p_gain u_gain (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (rot_valid),
    .in_stage  (rot_stage),
    .out_valid (gain_valid),
    .magnitude (gain_mag),
    .angle     (gain_ang)
  );

  // output register with skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_valid && polar.ready) begin
      if (skid_valid) begin
        skid_valid <= 1'b0;
      end else begin
        out_valid <= push;
      end
    end else if (!out_valid) begin
      out_valid <= push;
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_valid && polar.ready) begin
      if (skid_valid) begin
        out_mag <= skid_mag;
        out_ang <= skid_ang;
      end else begin
        out_mag <= gain_mag;
        out_ang <= gain_ang;
      end
    end else if (!out_valid) begin
      out_mag <= gain_mag;
      out_ang <= gain_ang;
    end else if (push) begin
      skid_mag <= gain_mag;
      skid_ang <= gain_ang;
    end
  end

  assign polar.valid     = out_valid;
  assign polar.magnitude = out_mag;
  assign polar.angle     = out_ang;

`ifndef SYNTHESIS
  a_skid_needs_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry holds data while output register is empty");

  a_skid_only_on_stall: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_valid) |-> $past(out_valid && !polar.ready))
    else $error("skid entry filled without an output stall");

  a_angle_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_ang <= AW'(ANGLE_PI)) && (out_ang >= -AW'(ANGLE_PI)))
    else $error("angle outside -pi .. pi");
`endif

endmodule

[rtl/c2p_fold.sv]
// c2p_fold: input stage. Detects axis samples, scales to guard bits and
// folds the left half plane into the right. Depends on c2p_pkg.
module c2p_fold import c2p_pkg::*; (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           en,
  input  logic                           in_valid,
  input  logic signed [SAMPLE_WIDTH-1:0] real_part,
  input  logic signed [SAMPLE_WIDTH-1:0] imag_part,
  output logic                           out_valid,
  output c2p_stage_t                     out_stage
);

  c2p_stage_t               stage_next;
  logic [SAMPLE_WIDTH:0]    abs_re;
  logic [SAMPLE_WIDTH:0]    abs_im;
  logic signed [DW-1:0]     xe;
  logic signed [DW-1:0]     ye;
  logic signed [ZW-1:0]     bz;

  always_comb begin
    abs_re = real_part[SAMPLE_WIDTH-1] ? -(SAMPLE_WIDTH+1)'(real_part)
                                       : (SAMPLE_WIDTH+1)'(real_part);
    abs_im = imag_part[SAMPLE_WIDTH-1] ? -(SAMPLE_WIDTH+1)'(imag_part)
                                       : (SAMPLE_WIDTH+1)'(imag_part);
    xe = DW'(real_part) <<< GUARD_BITS;
    ye = DW'(imag_part) <<< GUARD_BITS;

    stage_next.bypass = (imag_part == '0) || (real_part == '0);
    if (imag_part == '0) begin
      stage_next.bmag = MW'(abs_re);
      bz = real_part[SAMPLE_WIDTH-1] ? ANGLE_PI : '0;
    end else begin
      stage_next.bmag = MW'(abs_im);
      bz = imag_part[SAMPLE_WIDTH-1] ? -ANGLE_HALF_PI : ANGLE_HALF_PI;
    end
    stage_next.bang = AW'(bz);

    if (real_part[SAMPLE_WIDTH-1]) begin
      stage_next.x = -xe;
      stage_next.y = -ye;
      stage_next.z = imag_part[SAMPLE_WIDTH-1] ? -ANGLE_PI : ANGLE_PI;
    end else begin
      stage_next.x = xe;
      stage_next.y = ye;
      stage_next.z = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_stage <= stage_next;
    end
  end

endmodule

[rtl/c2p_cordic.sv]
// c2p_cordic: vectoring micro-rotations, one registered stage per
// iteration. Depends on c2p_pkg.
module c2p_cordic import c2p_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       en,
  input  logic       in_valid,
  input  c2p_stage_t in_stage,
  output logic       out_valid,
  output c2p_stage_t out_stage
);

  c2p_stage_t          s [ITERATIONS];
  logic [ITERATIONS-1:0] v;

  function automatic c2p_stage_t rotate(input c2p_stage_t a, input int unsigned i);
    c2p_stage_t           r;
    logic signed [DW-1:0] dx;
    logic signed [DW-1:0] dy;
    logic signed [ZW-1:0] t;
    r  = a;
    dx = a.y >>> i;
    dy = a.x >>> i;
    t  = atan_q13(i);
    if (!a.y[DW-1]) begin
      r.x = a.x + dx;
      r.y = a.y - dy;
      r.z = a.z + t;
    end else begin
      r.x = a.x - dx;
      r.y = a.y + dy;
      r.z = a.z - t;
    end
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[ITERATIONS-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s[0] <= rotate(in_stage, 0);
      for (int i = 1; i < ITERATIONS; i++) begin
        s[i] <= rotate(s[i-1], i);
      end
    end
  end

  assign out_valid = v[ITERATIONS-1];
  assign out_stage = s[ITERATIONS-1];

endmodule

[rtl/c2p_gain.sv]
// c2p_gain: gain correction as two partial products, angle clamp, then
// rounding, saturation and axis bypass select. Depends on c2p_pkg.
module c2p_gain import c2p_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_valid,
  input  c2p_stage_t           in_stage,
  output logic                 out_valid,
  output logic [MW-1:0]        magnitude,
  output logic signed [AW-1:0] angle
);

  logic [DW-2:0]             xs;
  logic signed [ZW-1:0]      zc;
  logic [HI_W+GAIN_W-1:0]    hi_prod;
  logic [LO_W+GAIN_W-1:0]    lo_prod;
  logic signed [AW-1:0]      z_sat;
  logic                      bypass;
  logic [MW-1:0]             bmag;
  logic signed [AW-1:0]      bang;
  logic [SUM_W-1:0]          sum;
  logic [SUM_W-GUARD_BITS-1:0] mag_full;

  always_comb begin
    xs = in_stage.x[DW-1] ? '0 : in_stage.x[DW-2:0];
    zc = in_stage.z;
    if (in_stage.z > ANGLE_PI) begin
      zc = ANGLE_PI;
    end else if (in_stage.z < -ANGLE_PI) begin
      zc = -ANGLE_PI;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hi_prod <= (HI_W+GAIN_W)'(xs[DW-2:LO_W]) * (HI_W+GAIN_W)'(GAIN_Q24);
      lo_prod <= (LO_W+GAIN_W)'(xs[LO_W-1:0]) * (LO_W+GAIN_W)'(GAIN_Q24);
      z_sat   <= AW'(zc);
      bypass  <= in_stage.bypass;
      bmag    <= in_stage.bmag;
      bang    <= in_stage.bang;
    end
  end

  always_comb begin
    sum = SUM_W'(hi_prod) + SUM_W'(lo_prod[LO_W+GAIN_W-1:LO_W])
        + (SUM_W'(1) << (GUARD_BITS - 1));
    mag_full = sum[SUM_W-1:GUARD_BITS];
    if (bypass) begin
      magnitude = bmag;
      angle     = bang;
    end else begin
      magnitude = (|mag_full[SUM_W-GUARD_BITS-1:MW]) ? '1 : mag_full[MW-1:0];
      angle     = z_sat;
    end
  end

endmodule

[test/tb_complex_to_polar_converter.sv]
`timescale 1ns / 100ps
// tb_complex_to_polar_converter: self-checking bench for the CORDIC complex to polar
// converter; directed table then random samples checked against a local predictor.
// Depends on c2p_pkg, c2p_sample_if, c2p_polar_if and complex_to_polar_converter.
module tb_complex_to_polar_converter;
  import c2p_pkg::*;

  localparam int RANDOM_ITEMS   = 530;
  localparam int LONG_STALL     = 300;
  localparam int DRAIN_CYCLES   = 40;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int NUM_ROWS       = 22;
  localparam longint unsigned ROUND_HALF = 64'd32768;

  typedef struct packed {
    logic [MW-1:0]        magnitude;
    logic signed [AW-1:0] angle;
  } polar_t;

  typedef struct packed {
    logic signed [SAMPLE_WIDTH-1:0] re;
    logic signed [SAMPLE_WIDTH-1:0] im;
    logic                           given;
    logic [MW-1:0]                  mag;
    logic signed [AW-1:0]           ang;
  } sample_row_t;

  localparam int ATAN_Q13 [14] = '{6434, 3798, 2007, 1019, 511, 256, 128, 64,
                                   32, 16, 8, 4, 2, 1};

  localparam logic signed [SAMPLE_WIDTH-1:0] CORNERS [6] =
    '{-16'sd32768, -16'sd32767, -16'sd1, 16'sd0, 16'sd1, 16'sd32767};

  sample_row_t directed_rows [NUM_ROWS] = '{
    '{16'sd0,       16'sd0,       1'b1, 16'd0,     16'sd0},
    '{16'sd32767,   16'sd0,       1'b1, 16'd32767, 16'sd0},
    '{-16'sd32768,  16'sd0,       1'b1, 16'd32768, 16'sd25736},
    '{-16'sd1,      16'sd0,       1'b1, 16'd1,     16'sd25736},
    '{16'sd1,       16'sd0,       1'b1, 16'd1,     16'sd0},
    '{16'sd0,       16'sd32767,   1'b1, 16'd32767, 16'sd12868},
    '{16'sd0,       -16'sd32768,  1'b1, 16'd32768, -16'sd12868},
    '{16'sd0,       -16'sd1,      1'b1, 16'd1,     -16'sd12868},
    '{16'sd32767,   16'sd32767,   1'b0, 16'd0,     16'sd0},
    '{-16'sd32768,  -16'sd32768,  1'b0, 16'd0,     16'sd0},
    '{-16'sd32768,  16'sd32767,   1'b0, 16'd0,     16'sd0},
    '{16'sd32767,   -16'sd32768,  1'b0, 16'd0,     16'sd0},
    '{16'sd1,       16'sd1,       1'b0, 16'd0,     16'sd0},
    '{-16'sd1,      16'sd1,       1'b0, 16'd0,     16'sd0},
    '{-16'sd1,      -16'sd1,      1'b0, 16'd0,     16'sd0},
    '{16'sd1,       -16'sd1,      1'b0, 16'd0,     16'sd0},
    '{-16'sd32768,  16'sd1,       1'b0, 16'd0,     16'sd0},
    '{-16'sd32768,  -16'sd1,      1'b0, 16'd0,     16'sd0},
    '{-16'sd1,      -16'sd32768,  1'b0, 16'd0,     16'sd0},
    '{16'sd21845,   -16'sd10923,  1'b0, 16'd0,     16'sd0},
    '{16'sd3,       16'sd4,       1'b0, 16'd0,     16'sd0},
    '{-16'sd3,      -16'sd4,      1'b0, 16'd0,     16'sd0}
  };

  logic clk;
  logic rst;
  c2p_sample_if sample_ch ();
  c2p_polar_if  polar_ch ();

  complex_to_polar_converter dut (
    .clk    (clk),
    .rst    (rst),
    .sample (sample_ch),
    .polar  (polar_ch)
  );

  polar_t pending_polar [$];
  int     mismatch_count = 0;
  int     quiet_cycles = 0;
  int     src_idle_pct = 34;
  int     snk_idle_pct = 83;
  logic   stall_on = 1'b0;
  event   stall_kick;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic polar_t predict_polar(logic signed [SAMPLE_WIDTH-1:0] re_in,
                                           logic signed [SAMPLE_WIDTH-1:0] im_in);
    longint re, im, x, y, dx, dy;
    longint unsigned ux, hi, lo, mag;
    int z, a;
    polar_t r;
    re = re_in;
    im = im_in;
    if (im == 0) begin
      mag = (re < 0) ? -re : re;
      z = (re < 0) ? int'(ANGLE_PI) : 0;
    end else if (re == 0) begin
      mag = (im < 0) ? -im : im;
      z = (im > 0) ? int'(ANGLE_HALF_PI) : -int'(ANGLE_HALF_PI);
    end else begin
      x = re <<< GUARD_BITS;
      y = im <<< GUARD_BITS;
      z = 0;
      if (x < 0) begin
        z = (y >= 0) ? int'(ANGLE_PI) : -int'(ANGLE_PI);
        x = -x;
        y = -y;
      end
      for (int i = 0; i < ITERATIONS; i++) begin
        a = (i < 14) ? ATAN_Q13[i] : 0;
        dx = y >>> i;
        dy = x >>> i;
        if (y >= 0) begin
          x = x + dx;
          y = y - dy;
          z = z + a;
        end else begin
          x = x - dx;
          y = y + dy;
          z = z - a;
        end
      end
      if (z > int'(ANGLE_PI)) z = int'(ANGLE_PI);
      if (z < -int'(ANGLE_PI)) z = -int'(ANGLE_PI);
      ux = (x < 0) ? 64'd0 : x;
      hi = ux >> 24;
      lo = ux & 64'hFF_FFFF;
      mag = (hi * GAIN_Q24 + ((lo * GAIN_Q24) >> 24) + ROUND_HALF) >> 16;
    end
    r.magnitude = (mag > 64'hFFFF) ? 16'hFFFF : mag[15:0];
    r.angle     = z[15:0];
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic push_sample(input logic signed [SAMPLE_WIDTH-1:0] re,
                             input logic signed [SAMPLE_WIDTH-1:0] im,
                             input logic given, input polar_t given_res);
    while ($urandom_range(99) < src_idle_pct) begin
      sample_ch.valid <= 1'b0;
      @(posedge clk);
    end
    sample_ch.valid     <= 1'b1;
    sample_ch.real_part <= re;
    sample_ch.imag_part <= im;
    @(posedge clk);
    while (!sample_ch.ready) @(posedge clk);
    pending_polar.push_back(given ? given_res : predict_polar(re, im));
  endtask

  function automatic logic signed [SAMPLE_WIDTH-1:0] near_zero();
    return SAMPLE_WIDTH'(int'($urandom_range(16)) - 8);
  endfunction

  // sink side: random back-pressure plus the long hold-off
  always @(posedge clk) begin
    polar_ch.ready <= !stall_on && ($urandom_range(99) >= snk_idle_pct);
  end

  initial begin
    forever begin
      @(stall_kick);
      stall_on <= 1'b1;
      repeat (LONG_STALL) @(posedge clk);
      stall_on <= 1'b0;
    end
  end

  always @(posedge clk) begin
    polar_t want;
    if (!rst && polar_ch.valid && polar_ch.ready) begin
      if (pending_polar.size() == 0) begin
        report_mismatch($sformatf("unexpected result mag=%0d ang=%0d",
                                  polar_ch.magnitude, polar_ch.angle));
      end else begin
        want = pending_polar.pop_front();
        if (polar_ch.magnitude !== want.magnitude)
          report_mismatch($sformatf("magnitude got %0d want %0d",
                                    polar_ch.magnitude, want.magnitude));
        if (polar_ch.angle !== want.angle)
          report_mismatch($sformatf("angle got %0d want %0d",
                                    polar_ch.angle, want.angle));
      end
    end
    if ((sample_ch.valid && sample_ch.ready) || (polar_ch.valid && polar_ch.ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("complex_to_polar_converter verification failed");
      $finish;
    end
  end

  initial begin
    logic signed [SAMPLE_WIDTH-1:0] re, im;
    polar_t given_res;
    int shape, t;
    rst                 <= 1'b1;
    sample_ch.valid     <= 1'b0;
    sample_ch.real_part <= '0;
    sample_ch.imag_part <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      given_res.magnitude = directed_rows[i].mag;
      given_res.angle     = directed_rows[i].ang;
      push_sample(directed_rows[i].re, directed_rows[i].im, directed_rows[i].given,
                  given_res);
    end

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS / 3) begin
        src_idle_pct = 83;
        snk_idle_pct <= 34;
      end
      if (n == 2 * RANDOM_ITEMS / 3) begin
        src_idle_pct = 0;
        snk_idle_pct <= 0;
        -> stall_kick;
      end
      shape = $urandom_range(99);
      if (shape < 35) begin
        re = SAMPLE_WIDTH'($urandom);
        im = SAMPLE_WIDTH'($urandom);
      end else if (shape < 50) begin
        t = $urandom;
        if ($urandom_range(1)) begin
          re = t[15:0];
          im = '0;
        end else begin
          re = '0;
          im = t[15:0];
        end
      end else if (shape < 65) begin
        re = CORNERS[$urandom_range(5)];
        im = CORNERS[$urandom_range(5)];
      end else if (shape < 80) begin
        re = near_zero();
        im = near_zero();
      end else if (shape < 90) begin
        // close to the negative real axis, where the angle wraps
        t  = $urandom_range(32768, 1);
        re = SAMPLE_WIDTH'(-t);
        im = SAMPLE_WIDTH'(int'($urandom_range(6)) - 3);
      end else begin
        re = near_zero();
        t  = $urandom;
        im = t[15:0];
      end
      push_sample(re, im, 1'b0, '0);
    end
    sample_ch.valid <= 1'b0;

    while (pending_polar.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0)
      $display("complex_to_polar_converter verification clean");
    else
      $display("complex_to_polar_converter verification failed");
    $finish;
  end

endmodule
